FILE: rtl/label_set_shortest_path_defines.svh
// Assertion macros shared by the shortest path block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef LABEL_SET_SHORTEST_PATH_DEFINES_SVH
`define LABEL_SET_SHORTEST_PATH_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LSP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsp check failed");

// Next-cycle implication, disabled during reset
`define LSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsp check failed");

`endif

FILE: rtl/lsp_pkg.sv
// Shared types and constants for the shortest path block.
// No dependencies; used by lsp_edge_store and label_set_shortest_path.
`default_nettype none

package lsp_pkg;

   localparam int VTX_W        = 6;
   localparam int LABEL_W      = 14;
   localparam int COST_W       = 12;
   localparam int RESULT_LIMIT = 32;

   localparam logic [LABEL_W-1:0] INF_LABEL = 14'd9999;

   // operation codes
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_RUN   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNREACH = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   typedef struct packed {
      logic [VTX_W-1:0]  src;
      logic [VTX_W-1:0]  tgt;
      logic [COST_W-1:0] cost;
   } edge_type;

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic [VTX_W-1:0]   pred;
   } vtx_type;

endpackage

`default_nettype wire

FILE: rtl/lsp_edge_store.sv
// Edge store: one synchronous memory of edges plus the fill count.
// Depends on lsp_pkg for edge_type.
`default_nettype none

module lsp_edge_store #(
   parameter int MAX_EDGES = 256
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            wr_en,
   input  wire                            clr,
   input  lsp_pkg::edge_type              wr_edge,
   input  wire                            rd_en,
   input  wire [$clog2(MAX_EDGES)-1:0]    rd_addr,
   output lsp_pkg::edge_type              rd_edge,
   output logic [$clog2(MAX_EDGES):0]     count,
   output logic                           full
);

   localparam int EW = $clog2(MAX_EDGES);

   lsp_pkg::edge_type mem [MAX_EDGES];
   lsp_pkg::edge_type rd_edge_ff;
   logic [EW:0]       count_ff;
   logic [EW:0]       count_in;

   assign full    = (count_ff == (EW+1)'(MAX_EDGES));
   assign count   = count_ff;
   assign rd_edge = rd_edge_ff;

   // append at the fill count; clear drops everything
   always_comb begin
      count_in = count_ff;
      if (clr) begin
         count_in = '0;
      end else if (wr_en && !full) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en && !full) begin
         mem[count_ff[EW-1:0]] <= wr_edge;
      end
      if (rd_en) begin
         rd_edge_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/label_set_shortest_path.sv
// Shortest path search over a loaded edge list, labels kept in memory.
// Load and clear are handled in idle; a load result appears the cycle after.
// A run clears MAX_VERTICES labels, then each pass scans the pending entries for
// the minimum label, removes it and relaxes every stored edge from it; the path
// walk reads labels back from the target, then emits the path. One item at a time.
// Results cannot be stalled. Reset clears control and the edge count.
`default_nettype none

`include "label_set_shortest_path_defines.svh"

module label_set_shortest_path #(
   parameter int MAX_VERTICES = 32,
   parameter int MAX_EDGES    = 256
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_operation,
   input  wire  [5:0]  req_from_vertex,
   input  wire  [5:0]  req_to_vertex,
   input  wire  [11:0] req_edge_cost,
   output logic        rsp_valid,
   output logic [5:0]  rsp_path_vertex,
   output logic [13:0] rsp_total_distance,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);

   localparam int VW      = $clog2(MAX_VERTICES);
   localparam int CW      = $clog2(MAX_VERTICES + 1);
   localparam int EW      = $clog2(MAX_EDGES);
   localparam int OUT_LIM = (MAX_VERTICES < lsp_pkg::RESULT_LIMIT) ?
                            MAX_VERTICES : lsp_pkg::RESULT_LIMIT;
   localparam logic [CW-1:0] OUT_LIM_C = CW'(OUT_LIM);
   localparam logic [CW-1:0] LAST_V    = CW'(MAX_VERTICES - 1);
   localparam logic [CW-1:0] MAX_V     = CW'(MAX_VERTICES);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CLR  = 4'd1;
   localparam logic [3:0] S_PRD  = 4'd2;
   localparam logic [3:0] S_VRD  = 4'd3;
   localparam logic [3:0] S_CMP  = 4'd4;
   localparam logic [3:0] S_RM1  = 4'd5;
   localparam logic [3:0] S_RM2  = 4'd6;
   localparam logic [3:0] S_ERD  = 4'd7;
   localparam logic [3:0] S_EV   = 4'd8;
   localparam logic [3:0] S_ECMP = 4'd9;
   localparam logic [3:0] S_WRD  = 4'd10;
   localparam logic [3:0] S_WV   = 4'd11;
   localparam logic [3:0] S_ORD  = 4'd12;
   localparam logic [3:0] S_OUT  = 4'd13;

   function automatic logic vtx_ok(input logic [5:0] v);
      return (v != 6'd0) && (v <= 6'(MAX_VERTICES));
   endfunction

   // control and working registers
   logic [3:0]              state_ff, state_in;
   logic [CW-1:0]           scan_ff, scan_in;
   logic [CW-1:0]           pcnt_ff, pcnt_in;
   logic [CW-1:0]           n_ff, n_in;
   logic [EW:0]             e_ff, e_in;
   logic [VW-1:0]           pos_ff, pos_in;
   logic [VW-1:0]           j_ff, j_in;
   logic [MAX_VERTICES-1:0] pflag_ff, pflag_in;
   logic [13:0]             best_ff, best_in;
   logic [13:0]             dist_ff, dist_in;
   logic [5:0]              sel_ff, sel_in;
   logic [5:0]              cand_ff, cand_in;
   logic [5:0]              src_ff, src_in;
   logic [5:0]              tgt_ff, tgt_in;
   logic [5:0]              v_ff, v_in;
   logic                    found_ff, found_in;

   // result registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  rsp_pv_ff, rsp_pv_in;
   logic [13:0] rsp_dist_ff, rsp_dist_in;
   logic [1:0]  rsp_st_ff, rsp_st_in;
   logic        rsp_last_ff, rsp_last_in;

   // label memory and pending set / path buffer memory
   lsp_pkg::vtx_type vmem [MAX_VERTICES];
   lsp_pkg::vtx_type vmem_q;
   logic             vm_we, vm_re;
   logic [VW-1:0]    vm_wa, vm_ra;
   lsp_pkg::vtx_type vm_wd;

   logic [5:0]    pmem [MAX_VERTICES];
   logic [5:0]    pmem_q;
   logic          pm_we, pm_re;
   logic [VW-1:0] pm_wa, pm_ra;
   logic [5:0]    pm_wd;

   // edge store interface
   logic              es_we, es_clr, es_re, es_full;
   lsp_pkg::edge_type es_wd, es_rd;
   logic [EW:0]       es_count;

   logic [13:0]   nl_w;
   logic [CW-1:0] nn_w;
   logic [CW-1:0] m_w;

   assign nl_w = best_ff + {2'b00, es_rd.cost};
   assign nn_w = n_ff + 1'b1;
   assign m_w  = (nn_w > OUT_LIM_C) ? OUT_LIM_C : nn_w;

   assign es_wd = '{src: req_from_vertex, tgt: req_to_vertex, cost: req_edge_cost};

   lsp_edge_store #(
      .MAX_EDGES (MAX_EDGES)
   ) u_edges (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (es_we),
      .clr     (es_clr),
      .wr_edge (es_wd),
      .rd_en   (es_re),
      .rd_addr (e_ff[EW-1:0]),
      .rd_edge (es_rd),
      .count   (es_count),
      .full    (es_full)
   );

   // sequencer: clear labels, select minimum, relax edges, walk and emit path
   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      pcnt_in      = pcnt_ff;
      n_in         = n_ff;
      e_in         = e_ff;
      pos_in       = pos_ff;
      j_in         = j_ff;
      pflag_in     = pflag_ff;
      best_in      = best_ff;
      dist_in      = dist_ff;
      sel_in       = sel_ff;
      cand_in      = cand_ff;
      src_in       = src_ff;
      tgt_in       = tgt_ff;
      v_in         = v_ff;
      found_in     = found_ff;
      rsp_valid_in = 1'b0;
      rsp_pv_in    = 6'd0;
      rsp_dist_in  = 14'd0;
      rsp_st_in    = lsp_pkg::ST_OK;
      rsp_last_in  = 1'b0;
      vm_we        = 1'b0;
      vm_wa        = '0;
      vm_wd        = '{label: lsp_pkg::INF_LABEL, pred: 6'd0};
      vm_re        = 1'b0;
      vm_ra        = '0;
      pm_we        = 1'b0;
      pm_wa        = '0;
      pm_wd        = 6'd0;
      pm_re        = 1'b0;
      pm_ra        = '0;
      es_we        = 1'b0;
      es_clr       = 1'b0;
      es_re        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_operation)
                  lsp_pkg::OP_LOAD: begin
                     es_we        = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     rsp_st_in    = es_full ? lsp_pkg::ST_FULL : lsp_pkg::ST_OK;
                  end
                  lsp_pkg::OP_RUN: begin
                     src_in = req_from_vertex;
                     tgt_in = req_to_vertex;
                     if (!vtx_ok(req_from_vertex) || !vtx_ok(req_to_vertex)) begin
                        rsp_valid_in = 1'b1;
                        rsp_last_in  = 1'b1;
                        rsp_dist_in  = lsp_pkg::INF_LABEL;
                        rsp_st_in    = lsp_pkg::ST_UNREACH;
                     end else begin
                        scan_in  = '0;
                        state_in = S_CLR;
                     end
                  end
                  lsp_pkg::OP_CLEAR: begin
                     es_clr = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // one label entry per cycle; source gets zero
         S_CLR: begin
            vm_we = 1'b1;
            vm_wa = scan_ff[VW-1:0];
            if (scan_ff[VW-1:0] == VW'(src_ff - 6'd1)) begin
               vm_wd.label = 14'd0;
            end
            if (scan_ff == LAST_V) begin
               pm_we    = 1'b1;
               pm_wa    = '0;
               pm_wd    = src_ff;
               pcnt_in  = CW'(1);
               pflag_in = '0;
               pflag_in[VW'(src_ff - 6'd1)] = 1'b1;
               scan_in  = '0;
               best_in  = lsp_pkg::INF_LABEL;
               found_in = 1'b0;
               state_in = S_PRD;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_PRD: begin
            if (scan_ff == pcnt_ff) begin
               if (found_ff) begin
                  state_in = S_RM1;
               end else begin
                  pcnt_in  = '0;
                  v_in     = tgt_ff;
                  n_in     = '0;
                  state_in = S_WRD;
               end
            end else begin
               pm_re    = 1'b1;
               pm_ra    = scan_ff[VW-1:0];
               state_in = S_VRD;
            end
         end
         S_VRD: begin
            cand_in  = pmem_q;
            vm_re    = 1'b1;
            vm_ra    = VW'(pmem_q - 6'd1);
            state_in = S_CMP;
         end
         // keep the first strict minimum
         S_CMP: begin
            if (vmem_q.label < best_ff) begin
               best_in  = vmem_q.label;
               sel_in   = cand_ff;
               pos_in   = scan_ff[VW-1:0];
               found_in = 1'b1;
            end
            scan_in  = scan_ff + 1'b1;
            state_in = S_PRD;
         end
         S_RM1: begin
            pm_re    = 1'b1;
            pm_ra    = VW'(pcnt_ff - 1'b1);
            state_in = S_RM2;
         end
         // move the last entry into the removed slot
         S_RM2: begin
            pm_we    = 1'b1;
            pm_wa    = pos_ff;
            pm_wd    = pmem_q;
            pcnt_in  = pcnt_ff - 1'b1;
            pflag_in[VW'(sel_ff - 6'd1)] = 1'b0;
            e_in     = '0;
            state_in = S_ERD;
         end
         S_ERD: begin
            if (e_ff == es_count) begin
               scan_in  = '0;
               best_in  = lsp_pkg::INF_LABEL;
               found_in = 1'b0;
               state_in = S_PRD;
            end else begin
               es_re    = 1'b1;
               state_in = S_EV;
            end
         end
         S_EV: begin
            if ((es_rd.src == sel_ff) && vtx_ok(es_rd.tgt)) begin
               vm_re    = 1'b1;
               vm_ra    = VW'(es_rd.tgt - 6'd1);
               state_in = S_ECMP;
            end else begin
               e_in     = e_ff + 1'b1;
               state_in = S_ERD;
            end
         end
         // relax one edge; if improved, append target when not already pending and room is left
         S_ECMP: begin
            if (vmem_q.label > nl_w) begin
               vm_we = 1'b1;
               vm_wa = VW'(es_rd.tgt - 6'd1);
               vm_wd = '{label: nl_w, pred: sel_ff};
               if (!pflag_ff[VW'(es_rd.tgt - 6'd1)] && (pcnt_ff < MAX_V)) begin
                  pm_we    = 1'b1;
                  pm_wa    = pcnt_ff[VW-1:0];
                  pm_wd    = es_rd.tgt;
                  pcnt_in  = pcnt_ff + 1'b1;
                  pflag_in[VW'(es_rd.tgt - 6'd1)] = 1'b1;
               end
            end
            e_in     = e_ff + 1'b1;
            state_in = S_ERD;
         end
         S_WRD: begin
            vm_re    = 1'b1;
            vm_ra    = VW'(v_ff - 6'd1);
            state_in = S_WV;
         end
         // record path vertex from target back toward source
         S_WV: begin
            if ((n_ff == '0) && (vmem_q.label >= lsp_pkg::INF_LABEL)) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_dist_in  = lsp_pkg::INF_LABEL;
               rsp_st_in    = lsp_pkg::ST_UNREACH;
               state_in     = S_IDLE;
            end else begin
               if (n_ff == '0) begin
                  dist_in = vmem_q.label;
               end
               pm_we = 1'b1;
               pm_wa = n_ff[VW-1:0];
               pm_wd = v_ff;
               n_in  = nn_w;
               if (vtx_ok(vmem_q.pred) && (n_ff < LAST_V)) begin
                  v_in     = vmem_q.pred;
                  state_in = S_WRD;
               end else begin
                  j_in     = VW'(m_w - 1'b1);
                  state_in = S_ORD;
               end
            end
         end
         S_ORD: begin
            pm_re    = 1'b1;
            pm_ra    = j_ff;
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_pv_in    = pmem_q;
            rsp_dist_in  = dist_ff;
            rsp_st_in    = lsp_pkg::ST_OK;
            rsp_last_in  = (j_ff == '0);
            if (j_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               j_in     = j_ff - 1'b1;
               state_in = S_ORD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pcnt_ff      <= pcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      n_ff        <= n_in;
      e_ff        <= e_in;
      pos_ff      <= pos_in;
      j_ff        <= j_in;
      pflag_ff    <= pflag_in;
      best_ff     <= best_in;
      dist_ff     <= dist_in;
      sel_ff      <= sel_in;
      cand_ff     <= cand_in;
      src_ff      <= src_in;
      tgt_ff      <= tgt_in;
      v_ff        <= v_in;
      found_ff    <= found_in;
      rsp_pv_ff   <= rsp_pv_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_last_ff <= rsp_last_in;
   end

   // label memory
   always_ff @(posedge clock) begin
      if (vm_we) begin
         vmem[vm_wa] <= vm_wd;
      end
      if (vm_re) begin
         vmem_q <= vmem[vm_ra];
      end
   end

   // pending set, reused as path buffer after the search
   always_ff @(posedge clock) begin
      if (pm_we) begin
         pmem[pm_wa] <= pm_wd;
      end
      if (pm_re) begin
         pmem_q <= pmem[pm_ra];
      end
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_path_vertex    = rsp_pv_ff;
   assign rsp_total_distance = rsp_dist_ff;
   assign rsp_status         = rsp_st_ff;
   assign rsp_last           = rsp_last_ff;

   `LSP_ASSERT_NOW(a_more_follows_busy, clock, reset, rsp_valid && !rsp_last, busy)
   `LSP_ASSERT_NOW(a_pcnt_bound, clock, reset, 1'b1, pcnt_ff <= MAX_V)
   `LSP_ASSERT_NEXT(a_out_strobes, clock, reset, state_ff == S_OUT, rsp_valid)
   `LSP_ASSERT_NOW(a_unreach_alone, clock, reset,
      rsp_valid && (rsp_status == lsp_pkg::ST_UNREACH), rsp_last)

endmodule

`default_nettype wire
